/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");

// Concurrent assertion that also holds while reset is held.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* rtl/gcb_pkg.sv */
// Package with constants, types and helpers of the register window blitter.
`timescale 1ns / 1ps
`default_nettype none
package gcb_pkg;

  // Video memory sizes.
  localparam int unsigned VramBigBytes   = 4194304;
  localparam int unsigned VramSmallBytes = 2097152;
  localparam int unsigned MaxVramBytesDef = VramBigBytes;

  localparam int unsigned OffW  = 22;
  localparam int unsigned DataW = 8;

  // Access codes.
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Control block offsets, relative to layout top minus 0x1000.
  localparam logic [11:0] LutBase = 12'h000;
  localparam logic [11:0] LutEnd  = 12'h200;
  localparam logic [11:0] IdBase  = 12'h200;
  localparam logic [11:0] IdEnd   = 12'h220;
  localparam logic [11:0] VtgBase = 12'h800;
  localparam logic [11:0] VtgEnd  = 12'h820;
  localparam logic [11:0] BltBase = 12'h900;
  localparam logic [11:0] BltEnd  = 12'h940;
  localparam logic [11:0] LnkBase = 12'hAC0;
  localparam logic [11:0] LnkEnd  = 12'hAE0;

  // Low byte of the memory layout register inside the timing block.
  localparam logic [4:0] VtgMemLo = 5'h1F;

  // Blit register indexes.
  localparam int unsigned NumBregs = 18;
  localparam logic [5:0] BrSrc  = 6'h00;
  localparam logic [5:0] BrDst  = 6'h04;
  localparam logic [5:0] BrSs   = 6'h08;
  localparam logic [5:0] BrDs   = 6'h0A;
  localparam logic [5:0] BrWid  = 6'h0C;
  localparam logic [5:0] BrRows = 6'h0E;
  localparam logic [5:0] BrCmd  = 6'h10;
  localparam logic [5:0] BrGo   = 6'h11;

  // Aux block.
  localparam logic [7:0] AuxVerA    = 8'h99;
  localparam logic [7:0] AuxVerB    = 8'hD9;
  localparam logic [7:0] AuxVersion = 8'h04;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic latch_req;
    logic access;
    logic blit_init;
    logic row_start;
    logic byte_rd;
    logic byte_wr;
    logic row_next;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic is_go;
    logic blit_empty;
    logic row_skip;
    logic last_byte;
    logic last_row;
  } sts_t;

  // Bytes of the read-only ID block.
  function automatic logic [7:0] id_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd24:   b = 8'h20;
      5'd25:   b = 8'h63;
      5'd26:   b = 8'h70;
      5'd27:   b = 8'h6D;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* rtl/gcb_if.sv */
// Valid/ready channel interfaces for requests, responses and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface gcb_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        aux;
  logic [21:0] offset;
  logic [7:0]  wdata;
  modport source (output valid, op, aux, offset, wdata, input ready);
  modport sink (input valid, op, aux, offset, wdata, output ready);
endinterface

interface gcb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  modport source (output valid, rdata, input ready);
  modport sink (input valid, rdata, output ready);
endinterface

interface gcb_cfg_if;
  logic valid;
  logic ready;
  logic window_4mb;
  modport source (output valid, window_4mb, input ready);
  modport sink (input valid, window_4mb, output ready);
endinterface
`default_nettype wire

/* rtl/gcb_ctrl.sv */
// Controller state machine that sequences bus accesses, blits and clearing.
`timescale 1ns / 1ps
`default_nettype none
module gcb_ctrl
  import gcb_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_BINIT,
    S_ROW,
    S_BRD,
    S_BWR,
    S_BNEXT,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd_o.access = 1'b1;
        state_d      = sts_i.is_go ? S_BINIT : S_RESP;
      end
      S_BINIT: begin
        cmd_o.blit_init = 1'b1;
        state_d         = sts_i.blit_empty ? S_RESP : S_ROW;
      end
      S_ROW: begin
        cmd_o.row_start = 1'b1;
        state_d         = sts_i.row_skip ? S_BNEXT : S_BRD;
      end
      S_BRD: begin
        cmd_o.byte_rd = 1'b1;
        state_d       = S_BWR;
      end
      S_BWR: begin
        cmd_o.byte_wr = 1'b1;
        state_d       = sts_i.last_byte ? S_BNEXT : S_BRD;
      end
      S_BNEXT: begin
        cmd_o.row_next = 1'b1;
        state_d        = sts_i.last_row ? S_RESP : S_ROW;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and output valid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* rtl/gcb_dpath.sv */
// Datapath: video memory, colour table, registers, decode and blit addressing.
`timescale 1ns / 1ps
`default_nettype none
module gcb_dpath
  import gcb_pkg::*;
#(
  parameter int unsigned MaxVramBytes = MaxVramBytesDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_win4_i,
  input  wire         op_i,
  input  wire         aux_i,
  input  wire  [21:0] offset_i,
  input  wire  [7:0]  wdata_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic [7:0]  rdata_o
);

  localparam int unsigned AW    = $clog2(MaxVramBytes);
  localparam bit          BigOk = (MaxVramBytes >= VramBigBytes);

  typedef enum logic [2:0] {RS_ZERO, RS_AUX, RS_LUT, RS_ID, RS_VRAM} rsrc_e;

  // Layout selection.
  logic        win4_q, lay_bit_q, big;
  logic [21:0] mask;
  logic [22:0] size;

  assign big  = win4_q && lay_bit_q && BigOk;
  assign mask = big ? 22'h3FFFFF : 22'h1FFFFF;
  assign size = big ? 23'h400000 : 23'h200000;

  // Request registers.
  logic        op_q, aux_q;
  logic [21:0] off_q;
  logic [7:0]  wdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      op_q    <= op_i;
      aux_q   <= aux_i;
      off_q   <= offset_i & mask;
      wdata_q <= wdata_i;
    end
  end

  // Region decode of the latched offset.
  logic        hit_top, in_lut, in_id, in_vtg, in_blt, in_lnk, plain, wr, aux_hit;
  logic [11:0] r;

  assign r       = off_q[11:0];
  assign hit_top = (&off_q[20:12]) && (!big || off_q[21]);
  assign in_lut  = hit_top && (r >= LutBase) && (r < LutEnd);
  assign in_id   = hit_top && (r >= IdBase) && (r < IdEnd);
  assign in_vtg  = hit_top && (r >= VtgBase) && (r < VtgEnd);
  assign in_blt  = hit_top && (r >= BltBase) && (r < BltEnd);
  assign in_lnk  = hit_top && (r >= LnkBase) && (r < LnkEnd);
  assign plain   = !in_lut && !in_id && !in_blt && !in_lnk;
  assign wr      = !aux_q && (op_q == OpWrite);
  assign aux_hit = (off_q[7:0] == AuxVerA) || (off_q[7:0] == AuxVerB);

  // Configuration and memory layout bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win4_q    <= 1'b0;
      lay_bit_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win4_q <= cfg_win4_i;
      end
      if (cmd_i.access && wr && in_vtg && !in_lut && (r[4:0] == VtgMemLo)) begin
        lay_bit_q <= wdata_q[1];
      end
    end
  end

  // Blit registers that the engine uses.
  logic [7:0] breg_q [NumBregs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBregs; i++) begin
        breg_q[i] <= 8'h00;
      end
    end else if (cmd_i.access && wr && in_blt && (r[5:0] < 6'(NumBregs))) begin
      breg_q[r[4:0]] <= wdata_q;
    end
  end

  assign sts_o.is_go = wr && in_blt && (r[5:0] == BrGo) && wdata_q[0];

  // Clearing sweep counter.
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign sts_o.clear_last = (clr_q == AW'(MaxVramBytes - 1));

  // Colour table as two byte memories, zeroed by the clearing sweep.
  logic [7:0] ct_hi_mem [256];
  logic [7:0] ct_lo_mem [256];
  logic [7:0] ct_hi_q, ct_lo_q;
  logic [7:0] ct_idx, ct_wa, ct_wd;
  logic       ct_we;

  assign ct_idx = r[8:1];
  assign ct_we  = cmd_i.access && wr && in_lut;
  assign ct_wa  = cmd_i.clear_step ? clr_q[7:0] : ct_idx;
  assign ct_wd  = cmd_i.clear_step ? 8'h00 : wdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step || (ct_we && !r[0])) begin
      ct_hi_mem[ct_wa] <= ct_wd;
    end
    if (cmd_i.clear_step || (ct_we && r[0])) begin
      ct_lo_mem[ct_wa] <= ct_wd;
    end
    if (cmd_i.access) begin
      ct_hi_q <= ct_hi_mem[ct_idx];
      ct_lo_q <= ct_lo_mem[ct_idx];
    end
  end

  // Blit engine registers.
  logic [21:0] b_src_q, b_dst_q;
  logic [15:0] b_ss_q, b_ds_q, b_wid_q, b_rows_q, k_q, cnt_q;
  logic        b_fill_q, b_desc_q, back_q;
  logic        asc, over, fwd;
  logic [15:0] wid_reg, rows_reg, so;
  logic [21:0] saddr, daddr;

  assign wid_reg  = {breg_q[BrWid[4:0]], breg_q[BrWid[4:0] + 5'd1]};
  assign rows_reg = {breg_q[BrRows[4:0]], breg_q[BrRows[4:0] + 5'd1]};
  assign sts_o.blit_empty = (wid_reg == 16'h0) || (rows_reg == 16'h0);

  assign asc  = !b_fill_q && !b_desc_q;
  assign over = (({1'b0, b_src_q} + {7'b0, b_wid_q}) > size)
             || (({1'b0, b_dst_q} + {7'b0, b_wid_q}) > size);
  assign fwd  = (b_dst_q <= b_src_q);
  assign sts_o.row_skip  = asc && over;
  assign sts_o.last_byte = (cnt_q == 16'd1);
  assign sts_o.last_row  = (b_rows_q == 16'd1);

  // Fill sources repeat the upper 32 bytes of the first 64.
  assign so    = (k_q[15:6] == 10'h0) ? k_q : {10'h0, 1'b1, k_q[4:0]};
  assign saddr = (b_desc_q ? (b_src_q - {6'h0, k_q})
                           : (b_src_q + {6'h0, (b_fill_q ? so : k_q)})) & mask;
  assign daddr = (b_desc_q ? (b_dst_q - {6'h0, k_q}) : (b_dst_q + {6'h0, k_q})) & mask;

  // The fill bit takes precedence over the descending bit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.blit_init) begin
      b_src_q  <= {breg_q[BrSrc[4:0] + 5'd1][5:0], breg_q[BrSrc[4:0] + 5'd2],
                   breg_q[BrSrc[4:0] + 5'd3]} & mask;
      b_dst_q  <= {breg_q[BrDst[4:0] + 5'd1][5:0], breg_q[BrDst[4:0] + 5'd2],
                   breg_q[BrDst[4:0] + 5'd3]} & mask;
      b_ss_q   <= {breg_q[BrSs[4:0]], breg_q[BrSs[4:0] + 5'd1]};
      b_ds_q   <= {breg_q[BrDs[4:0]], breg_q[BrDs[4:0] + 5'd1]};
      b_wid_q  <= wid_reg;
      b_rows_q <= rows_reg;
      b_fill_q <= breg_q[BrCmd[4:0] + 5'd1][2];
      b_desc_q <= breg_q[BrCmd[4:0] + 5'd1][1] && !breg_q[BrCmd[4:0] + 5'd1][2];
    end
    if (cmd_i.row_start) begin
      back_q <= asc && !fwd;
      k_q    <= (asc && !fwd) ? (b_wid_q - 16'd1) : 16'd0;
      cnt_q  <= b_wid_q;
    end
    if (cmd_i.byte_wr) begin
      k_q   <= back_q ? (k_q - 16'd1) : (k_q + 16'd1);
      cnt_q <= cnt_q - 16'd1;
    end
    if (cmd_i.row_next) begin
      b_src_q  <= (b_src_q + {{6{b_ss_q[15]}}, b_ss_q}) & mask;
      b_dst_q  <= (b_dst_q + {{6{b_ds_q[15]}}, b_ds_q}) & mask;
      b_rows_q <= b_rows_q - 16'd1;
    end
  end

  // Video memory: one write port, one registered read port.
  logic [7:0]    vram_mem [MaxVramBytes];
  logic [7:0]    vram_rd_q, vram_wd;
  logic [AW-1:0] vram_wa, vram_ra;
  logic          vram_we, vram_re;

  assign vram_we = cmd_i.clear_step || cmd_i.byte_wr || (cmd_i.access && wr && in_vtg == 1'b0
                   && plain);
  assign vram_re = cmd_i.byte_rd || (cmd_i.access && !aux_q && (op_q == OpRead) && plain);
  assign vram_wa = cmd_i.clear_step ? clr_q : (cmd_i.byte_wr ? daddr[AW-1:0] : off_q[AW-1:0]);
  assign vram_wd = cmd_i.clear_step ? 8'h00 : (cmd_i.byte_wr ? vram_rd_q : wdata_q);
  assign vram_ra = cmd_i.byte_rd ? saddr[AW-1:0] : off_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (vram_we) begin
      vram_mem[vram_wa] <= vram_wd;
    end
    if (vram_re) begin
      vram_rd_q <= vram_mem[vram_ra];
    end
  end

  // Read source selection, registered at the access step.
  rsrc_e      rsrc_q;
  logic [4:0] id_idx_q;
  logic       lut_odd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.access) begin
      id_idx_q  <= r[4:0];
      lut_odd_q <= r[0];
      if (aux_q) begin
        rsrc_q <= (op_q == OpRead && aux_hit) ? RS_AUX : RS_ZERO;
      end else if (op_q == OpWrite) begin
        rsrc_q <= RS_ZERO;
      end else if (in_lut) begin
        rsrc_q <= RS_LUT;
      end else if (in_id) begin
        rsrc_q <= RS_ID;
      end else if (plain) begin
        rsrc_q <= RS_VRAM;
      end else begin
        rsrc_q <= RS_ZERO;
      end
    end
  end

  // Output data register.
  logic [7:0] rdata_d, rdata_q;

  always_comb begin
    case (rsrc_q)
      RS_AUX:  rdata_d = AuxVersion;
      RS_LUT:  rdata_d = lut_odd_q ? ct_lo_q : ct_hi_q;
      RS_ID:   rdata_d = id_byte(id_idx_q);
      RS_VRAM: rdata_d = vram_rd_q;
      default: rdata_d = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rdata_q <= rdata_d;
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/graphics_card_register_window_blitter_unit.sv */
// Top level of the register window blitter: controller plus datapath.
// After reset a sweep over MaxVramBytes addresses (4194304 by default) clears video memory
// and colour table; no request is taken during that pass, configuration is.
// A plain read or write is accepted only while idle, so a new request is taken only after
// the result of the last one is loaded for output. A GO write copies width bytes per row for
// rows rows, skipping an ascending row past the layout; each byte is read, then written.
`timescale 1ns / 1ps
`default_nettype none
module graphics_card_register_window_blitter_unit
  import gcb_pkg::*;
#(
  parameter int unsigned MaxVramBytes = MaxVramBytesDef
) (
  input wire         clk_i,
  input wire         rst_ni,
  gcb_req_if.sink    req_i,
  gcb_rsp_if.source  rsp_o,
  gcb_cfg_if.sink    cfg_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  gcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gcb_dpath #(
    .MaxVramBytes (MaxVramBytes)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_win4_i (cfg_i.window_4mb),
    .op_i       (req_i.op),
    .aux_i      (req_i.aux),
    .offset_i   (req_i.offset),
    .wdata_i    (req_i.wdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rdata_o    (rsp_o.rdata)
  );

endmodule
`default_nettype wire

/* rtl/gcb_chk.sv */
// Port-level checker for the register window blitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gcb_chk (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [7:0] out_rdata_i,
  input wire       cfg_ready_i
);

  // Items accepted whose result beat has not yet been taken.
  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else if (in_acc && !out_acc && pend_q != 2'd3) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc && pend_q != 2'd0) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rdata_i))
  `ASSERT_CLK(a_no_spurious, clk_i, rst_ni, out_valid_i |-> pend_q != 2'd0)
  `ASSERT_CLK(a_pend_bound, clk_i, rst_ni, pend_q != 2'd3)
  `ASSERT_ALWAYS(a_cfg_ready, clk_i, !rst_ni || cfg_ready_i)

endmodule

bind graphics_card_register_window_blitter_unit gcb_chk u_gcb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_rdata_i (rsp_o.rdata),
  .cfg_ready_i (cfg_i.ready)
);
`default_nettype wire
